// ===== sv/tlp_pkg.sv =====
package tlp_pkg;

    localparam int DATA_W    = 16;
    localparam int ACT_W     = 3;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int OCNT_W    = 5;
    localparam int ROW_W     = CNT_W;
    localparam int ACC_W     = 48;
    localparam int OIDX_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam int CNT_MAX  = 2 ** CNT_W - 1;
    localparam int OCNT_MAX = 2 ** OCNT_W - 1;
    localparam int DATA_MAX = 2 ** (DATA_W - 1) - 1;
    localparam int DATA_MIN = -(2 ** (DATA_W - 1));

    localparam int RST_INPUT_COUNT  = 64;
    localparam int RST_HIDDEN_COUNT = 64;
    localparam int RST_OUTPUT_COUNT = 16;

    localparam logic [ACT_W-1:0] ACT_LOAD_W1    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B1    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD_W2    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOAD_B2    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LOAD_INPUT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_EVAL       = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HIDDEN_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic             valid;
        logic             layer2;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } t_rd;

    typedef struct packed {
        logic             valid;
        logic             layer2;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
    } t_tag;

    typedef struct packed {
        logic             valid;
        logic             layer2;
        logic [ROW_W-1:0] row;
        t_data            value;
    } t_res;

endpackage

// ===== sv/tlp_seq.sv =====
module tlp_seq
    import tlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_start,
    input  logic              i_pipe_empty,
    input  logic [CNT_W-1:0]  i_in_cnt,
    input  logic [CNT_W-1:0]  i_hid_cnt,
    input  logic [OCNT_W-1:0] i_out_cnt,
    output t_rd               o_rd,
    output logic              o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_L1     = 3'd1;
    localparam logic [2:0] S_DRAIN1 = 3'd2;
    localparam logic [2:0] S_L2     = 3'd3;
    localparam logic [2:0] S_DRAIN2 = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic [ROW_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] ncol, nrow;
    logic             col_end, row_end;

    always_comb begin
        ncol    = (r_state == S_L2) ? i_hid_cnt : i_in_cnt;
        nrow    = (r_state == S_L2) ? CNT_W'(i_out_cnt) : i_hid_cnt;
        col_end = (r_col == ncol - 1'b1);
        row_end = (r_row == nrow - 1'b1);
    end

    always_comb begin
        o_rd.valid  = (r_state inside {S_L1, S_L2});
        o_rd.layer2 = (r_state == S_L2);
        o_rd.first  = (r_col == '0);
        o_rd.last   = col_end;
        o_rd.row    = r_row;
        o_rd.col    = r_col;
        o_busy      = (r_state != S_IDLE);
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_L1;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            S_L1, S_L2: begin
                if (i_adv) begin
                    if (col_end) begin
                        n_col = '0;
                        if (row_end) begin
                            n_row   = '0;
                            n_state = (r_state == S_L1) ? S_DRAIN1 : S_DRAIN2;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            S_DRAIN1: begin
                if (i_pipe_empty) begin
                    n_state = S_L2;
                end
            end
            S_DRAIN2: begin
                if (i_pipe_empty) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

endmodule

// ===== sv/tlp_mac.sv =====
module tlp_mac
    import tlp_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_tag  i_tag,
    input  t_data i_a,
    input  t_data i_b,
    input  t_data i_bias,
    output t_res  o_res,
    output logic  o_busy
);

    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'((64'(1) << FRAC_BITS) >> 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(DATA_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(DATA_MIN);
    localparam t_data DMAX = DATA_W'(DATA_MAX);
    localparam t_data DMIN = DATA_W'(DATA_MIN);

    t_tag                      r_s2_tag, r_s3_tag, r_s4_tag;
    logic signed [2*DATA_W-1:0] r_prod;
    t_data                     r_s2_bias;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [ACC_W-1:0]   r_scaled;
    t_data                     n_value;

    always_comb begin
        if (r_s2_tag.first) begin
            n_acc = (ACC_W'(r_s2_bias) <<< FRAC_BITS) + ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_comb begin
        if (r_s4_tag.layer2) begin
            if (r_scaled > SAT_HI) begin
                n_value = DMAX;
            end else if (r_scaled < SAT_LO) begin
                n_value = DMIN;
            end else begin
                n_value = r_scaled[DATA_W-1:0];
            end
        end else begin
            if (r_scaled <= 0) begin
                n_value = '0;
            end else if (r_scaled > SAT_HI) begin
                n_value = DMAX;
            end else begin
                n_value = r_scaled[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag <= '0;
            r_s3_tag <= '0;
            r_s4_tag <= '0;
        end else if (i_adv) begin
            r_s2_tag <= i_tag;
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= {r_s3_tag.valid && r_s3_tag.last, r_s3_tag.layer2, r_s3_tag.first,
                         r_s3_tag.last, r_s3_tag.row};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod    <= i_a * i_b;
            r_s2_bias <= i_bias;
            if (r_s2_tag.valid) begin
                r_acc <= n_acc;
            end
            r_scaled <= (r_acc + ROUND) >>> FRAC_BITS;
        end
    end

    always_comb begin
        o_res.valid  = r_s4_tag.valid;
        o_res.layer2 = r_s4_tag.layer2;
        o_res.row    = r_s4_tag.row;
        o_res.value  = n_value;
        o_busy       = r_s2_tag.valid || r_s3_tag.valid || r_s4_tag.valid;
    end

endmodule

// ===== sv/two_layer_perceptron_relu.sv =====
// Channel   Direction  Handshake                Payload
// request   in         i_in_valid / o_in_stall  i_action, i_row, i_column, i_value
// result    out        o_out_valid / i_out_stall o_out_index, o_out_value, o_last
// config    in         psel, penable, pready    paddr, pwdata, prdata
//
// A load request is accepted back to back while no evaluation is in progress.
// An evaluate request stalls the input until both layers have run and the pipeline has drained;
// one shared 16x16 multiplier and accumulator handles one product per cycle unless stalled.
// A stalled result freezes the whole evaluation pipeline until it is taken.
// Reset sets the counts to their defaults; the weight, bias and data stores are not cleared.
module two_layer_perceptron_relu
    import tlp_pkg::*;
#(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_HIDDEN  = 64,
    parameter int MAX_OUTPUTS = 16,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [IDX_W-1:0]    i_row,
    input  logic [IDX_W-1:0]    i_column,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [OIDX_W-1:0]   o_out_index,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int W1D  = MAX_HIDDEN * MAX_INPUTS;
    localparam int W2D  = MAX_OUTPUTS * MAX_HIDDEN;
    localparam int W1AW = (W1D > 1) ? $clog2(W1D) : 1;
    localparam int W2AW = (W2D > 1) ? $clog2(W2D) : 1;
    localparam int XAW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int HAW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int OAW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    localparam logic [CNT_W-1:0] IN_LIM =
        (MAX_INPUTS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_INPUTS);
    localparam logic [CNT_W-1:0] HID_LIM =
        (MAX_HIDDEN > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_HIDDEN);
    localparam logic [OCNT_W-1:0] OUT_LIM =
        (MAX_OUTPUTS > OCNT_MAX) ? OCNT_W'(OCNT_MAX) : OCNT_W'(MAX_OUTPUTS);
    localparam logic [CNT_W-1:0] IN_RST =
        (MAX_INPUTS < RST_INPUT_COUNT) ? CNT_W'(MAX_INPUTS) : CNT_W'(RST_INPUT_COUNT);
    localparam logic [CNT_W-1:0] HID_RST =
        (MAX_HIDDEN < RST_HIDDEN_COUNT) ? CNT_W'(MAX_HIDDEN) : CNT_W'(RST_HIDDEN_COUNT);
    localparam logic [OCNT_W-1:0] OUT_RST =
        (MAX_OUTPUTS < RST_OUTPUT_COUNT) ? OCNT_W'(MAX_OUTPUTS)
                                         : OCNT_W'(RST_OUTPUT_COUNT);

    t_data r_w1_mem [W1D];
    t_data r_b1_mem [MAX_HIDDEN];
    t_data r_w2_mem [W2D];
    t_data r_b2_mem [MAX_OUTPUTS];
    t_data r_x_mem  [MAX_INPUTS];
    t_data r_h_mem  [MAX_HIDDEN];

    t_data r_w1_q, r_b1_q, r_w2_q, r_b2_q, r_x_q, r_h_q;
    t_tag  r_s1_tag;

    logic [CNT_W-1:0]  r_in_cnt, r_hid_cnt;
    logic [OCNT_W-1:0] r_out_cnt;
    logic [CNT_W-1:0]  wr_cnt;
    logic [OCNT_W-1:0] wr_ocnt;
    logic              cfg_wr;

    logic              r_out_valid;
    logic [OIDX_W-1:0] r_out_index;
    t_data             r_out_value;
    logic              r_last;

    logic in_acc, start, adv, seq_busy, mac_busy, pipe_empty;
    logic ld_w1, ld_b1, ld_w2, ld_b2, ld_x;
    logic [W1AW-1:0] w1_wa, w1_ra;
    logic [W2AW-1:0] w2_wa, w2_ra;
    t_rd   rd;
    t_tag  s1_tag_in;
    t_res  res;
    t_data mac_a, mac_b, mac_bias;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = seq_busy;
    assign adv        = !r_out_valid || !i_out_stall;
    assign pipe_empty = !r_s1_tag.valid && !mac_busy;

    always_comb begin
        ld_w1 = 1'b0;
        ld_b1 = 1'b0;
        ld_w2 = 1'b0;
        ld_b2 = 1'b0;
        ld_x  = 1'b0;
        start = 1'b0;
        if (in_acc) begin
            case (i_action)
                ACT_LOAD_W1: begin
                    ld_w1 = (int'(i_row) < MAX_HIDDEN) && (int'(i_column) < MAX_INPUTS);
                end
                ACT_LOAD_B1: begin
                    ld_b1 = (int'(i_row) < MAX_HIDDEN);
                end
                ACT_LOAD_W2: begin
                    ld_w2 = (int'(i_row) < MAX_OUTPUTS) && (int'(i_column) < MAX_HIDDEN);
                end
                ACT_LOAD_B2: begin
                    ld_b2 = (int'(i_row) < MAX_OUTPUTS);
                end
                ACT_LOAD_INPUT: begin
                    ld_x = (int'(i_column) < MAX_INPUTS);
                end
                ACT_EVAL: begin
                    start = 1'b1;
                end
                default: begin
                    start = 1'b0;
                end
            endcase
        end
    end

    assign w1_wa = W1AW'(int'(i_row) * MAX_INPUTS + int'(i_column));
    assign w2_wa = W2AW'(int'(i_row) * MAX_HIDDEN + int'(i_column));
    assign w1_ra = W1AW'(int'(rd.row) * MAX_INPUTS + int'(rd.col));
    assign w2_ra = W2AW'(int'(rd.row) * MAX_HIDDEN + int'(rd.col));

    always_ff @(posedge i_clk) begin
        if (ld_w1) begin
            r_w1_mem[w1_wa] <= i_value;
        end
        if (adv) begin
            r_w1_q <= r_w1_mem[w1_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_b1) begin
            r_b1_mem[HAW'(i_row)] <= i_value;
        end
        if (adv) begin
            r_b1_q <= r_b1_mem[HAW'(rd.row)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_w2) begin
            r_w2_mem[w2_wa] <= i_value;
        end
        if (adv) begin
            r_w2_q <= r_w2_mem[w2_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_b2) begin
            r_b2_mem[OAW'(i_row)] <= i_value;
        end
        if (adv) begin
            r_b2_q <= r_b2_mem[OAW'(rd.row)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_x) begin
            r_x_mem[XAW'(i_column)] <= i_value;
        end
        if (adv) begin
            r_x_q <= r_x_mem[XAW'(rd.col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid && !res.layer2) begin
            r_h_mem[HAW'(res.row)] <= res.value;
        end
        if (adv) begin
            r_h_q <= r_h_mem[HAW'(rd.col)];
        end
    end

    always_comb begin
        s1_tag_in.valid  = rd.valid;
        s1_tag_in.layer2 = rd.layer2;
        s1_tag_in.first  = rd.first;
        s1_tag_in.last   = rd.last;
        s1_tag_in.row    = rd.row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else if (adv) begin
            r_s1_tag <= s1_tag_in;
        end
    end

    assign mac_a    = r_s1_tag.layer2 ? r_w2_q : r_w1_q;
    assign mac_b    = r_s1_tag.layer2 ? r_h_q  : r_x_q;
    assign mac_bias = r_s1_tag.layer2 ? r_b2_q : r_b1_q;

    tlp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_start      (start),
        .i_pipe_empty (pipe_empty),
        .i_in_cnt     (r_in_cnt),
        .i_hid_cnt    (r_hid_cnt),
        .i_out_cnt    (r_out_cnt),
        .o_rd         (rd),
        .o_busy       (seq_busy)
    );

    tlp_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tag   (r_s1_tag),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_bias  (mac_bias),
        .o_res   (res),
        .o_busy  (mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res.valid && res.layer2) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid && res.layer2) begin
            r_out_index <= res.row[OIDX_W-1:0];
            r_out_value <= res.value;
            r_last      <= (res.row == CNT_W'(r_out_cnt) - 1'b1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_last      = r_last;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        if (pwdata[CNT_W-1:0] == '0) begin
            wr_cnt = CNT_W'(1);
        end else if (pwdata[CNT_W-1:0] > ((paddr[3:2] == REG_HIDDEN_COUNT) ? HID_LIM
                                                                           : IN_LIM)) begin
            wr_cnt = (paddr[3:2] == REG_HIDDEN_COUNT) ? HID_LIM : IN_LIM;
        end else begin
            wr_cnt = pwdata[CNT_W-1:0];
        end
        if (pwdata[OCNT_W-1:0] == '0) begin
            wr_ocnt = OCNT_W'(1);
        end else if (pwdata[OCNT_W-1:0] > OUT_LIM) begin
            wr_ocnt = OUT_LIM;
        end else begin
            wr_ocnt = pwdata[OCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= IN_RST;
            r_hid_cnt <= HID_RST;
            r_out_cnt <= OUT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_INPUT_COUNT: begin
                    r_in_cnt <= wr_cnt;
                end
                REG_HIDDEN_COUNT: begin
                    r_hid_cnt <= wr_cnt;
                end
                REG_OUTPUT_COUNT: begin
                    r_out_cnt <= wr_ocnt;
                end
                default: begin
                    r_in_cnt <= r_in_cnt;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_INPUT_COUNT:  prdata = 32'(r_in_cnt);
            REG_HIDDEN_COUNT: prdata = 32'(r_hid_cnt);
            REG_OUTPUT_COUNT: prdata = 32'(r_out_cnt);
            default:          prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!mac_busy && !r_s1_tag.valid))
        else $error("evaluation pipeline active while idle");

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an evaluation in progress");

    a_eval_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_action == ACT_EVAL) |=> o_in_stall)
        else $error("evaluate request did not start the sequencer");

    a_counts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_cnt != '0) && (r_hid_cnt != '0) && (r_out_cnt != '0))
        else $error("count register holds zero");
`endif

endmodule
